[rtl/rar_pkg.sv]
package rar_pkg;

	// Default operand width and the fixed widths of the command and result fields.
	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int OP_W              = 2;
	localparam int NUM_W             = 33;
	localparam int DEN_W             = 31;

	// Operation codes carried on the cmd field.
	typedef enum logic [OP_W-1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_SUM,
		ST_GINIT,
		ST_GCD,
		ST_DINIT,
		ST_DIV,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic mul3;
		logic sum;
		logic ginit;
		logic gstep;
		logic dinit;
		logic dstep;
		logic out_load;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic err;
		logic num_zero;
		logic gcd_eq;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

[rtl/rar_ctrl.sv]
module rar_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  rar_pkg::sts_t sts,
	output rar_pkg::ctl_t ctl
);
	import rar_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state: three multiplies, the signed sum, the GCD loop, the division loop.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_nxt = ST_MUL1;
			ST_MUL1:  state_nxt = sts.err ? ST_DONE : ST_MUL2;
			ST_MUL2:  state_nxt = ST_MUL3;
			ST_MUL3:  state_nxt = ST_SUM;
			ST_SUM:   state_nxt = ST_GINIT;
			ST_GINIT: state_nxt = sts.num_zero ? ST_DONE : ST_GCD;
			ST_GCD:   if (sts.gcd_eq) state_nxt = ST_DINIT;
			ST_DINIT: state_nxt = ST_DIV;
			ST_DIV:   if (sts.div_last) state_nxt = ST_DONE;
			ST_DONE:  if (sts.out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// Command decode.
	always_comb begin
		ctl          = '0;
		in_stall     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				ctl.load = in_valid;
			end
			ST_MUL1:  ctl.mul1 = 1'b1;
			ST_MUL2:  ctl.mul2 = 1'b1;
			ST_MUL3:  ctl.mul3 = 1'b1;
			ST_SUM:   ctl.sum = 1'b1;
			ST_GINIT: ctl.ginit = 1'b1;
			ST_GCD:   ctl.gstep = !sts.gcd_eq;
			ST_DINIT: ctl.dinit = 1'b1;
			ST_DIV:   ctl.dstep = 1'b1;
			ST_DONE:  ctl.out_load = sts.out_free;
			default:  ctl = '0;
		endcase
	end

endmodule

[rtl/rar_dp.sv]
module rar_dp #(
	parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rar_pkg::ctl_t                     ctl,
	output rar_pkg::sts_t                     sts,
	input  logic [rar_pkg::OP_W-1:0]          cmd,
	input  logic signed [OPERAND_WIDTH-1:0]   left_num,
	input  logic signed [OPERAND_WIDTH-1:0]   left_den,
	input  logic signed [OPERAND_WIDTH-1:0]   right_num,
	input  logic signed [OPERAND_WIDTH-1:0]   right_den,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [rar_pkg::NUM_W-1:0]  result_num,
	output logic [rar_pkg::DEN_W-1:0]         result_den,
	output logic                              status
);
	import rar_pkg::*;

	localparam int W  = OPERAND_WIDTH;
	localparam int GW = 2 * W;
	localparam int KW = $clog2(GW);
	localparam int XN = (GW + 1 > NUM_W) ? GW + 1 : NUM_W;
	localparam int XD = (GW > DEN_W) ? GW : DEN_W;

	// Sign and magnitude of the incoming operands.
	logic [W-1:0] ln_raw, ld_raw, rn_raw, rd_raw;
	logic [W-1:0] ln_mag, ld_mag, rn_mag, rd_mag;
	logic         in_err;

	assign ln_raw = left_num;
	assign ld_raw = left_den;
	assign rn_raw = right_num;
	assign rd_raw = right_den;
	assign ln_mag = ln_raw[W-1] ? W'(~ln_raw + 1'b1) : ln_raw;
	assign ld_mag = ld_raw[W-1] ? W'(~ld_raw + 1'b1) : ld_raw;
	assign rn_mag = rn_raw[W-1] ? W'(~rn_raw + 1'b1) : rn_raw;
	assign rd_mag = rd_raw[W-1] ? W'(~rd_raw + 1'b1) : rd_raw;
	assign in_err = (ld_raw == '0) || (rd_raw == '0)
		|| ((op_t'(cmd) == OP_DIV) && (rn_raw == '0));

	op_t           op_q;
	logic          err_q;
	logic [W-1:0]  ln_q, ld_q, rn_q, rd_q;
	logic          ln_neg_q, ld_neg_q, rn_neg_q, rd_neg_q;
	logic [GW-1:0] t1_q, t2_q, dn_q, nm_q;
	logic          t1_neg_q, t2_neg_q, dn_neg_q, nm_neg_q;
	logic [GW-1:0] a_q, b_q, g_q, nq_q, dq_q;
	logic [KW-1:0] k_q, cnt_q;
	logic [GW:0]   nr_q, dr_q;
	logic          out_valid_q;
	logic [NUM_W-1:0] res_num_q;
	logic [DEN_W-1:0] res_den_q;
	logic             status_q;

	// Shared multiplier: operands chosen by the step and the operation.
	logic [W-1:0]  mul_a, mul_b;
	logic          mul_an, mul_bn;
	logic [GW-1:0] prod;
	logic          prod_neg;

	always_comb begin
		mul_a  = ld_q;
		mul_an = ld_neg_q;
		mul_b  = rd_q;
		mul_bn = rd_neg_q;
		if (ctl.mul1) begin
			mul_a  = ln_q;
			mul_an = ln_neg_q;
			if (op_q == OP_MUL) begin
				mul_b  = rn_q;
				mul_bn = rn_neg_q;
			end
		end else if (ctl.mul2) begin
			mul_a  = rn_q;
			mul_an = rn_neg_q ^ (op_q == OP_SUB);
			mul_b  = ld_q;
			mul_bn = ld_neg_q;
		end else if (op_q == OP_DIV) begin
			mul_b  = rn_q;
			mul_bn = rn_neg_q;
		end
	end

	assign prod     = GW'(mul_a) * GW'(mul_b);
	assign prod_neg = (mul_an ^ mul_bn) && (prod != '0);

	// Signed-magnitude sum of the two cross products.
	logic [GW-1:0] sum_mag;
	logic          sum_neg;

	always_comb begin
		if (t1_neg_q == t2_neg_q) begin
			sum_mag = t1_q + t2_q;
			sum_neg = t1_neg_q;
		end else if (t1_q >= t2_q) begin
			sum_mag = t1_q - t2_q;
			sum_neg = t1_neg_q;
		end else begin
			sum_mag = t2_q - t1_q;
			sum_neg = t2_neg_q;
		end
		if (sum_mag == '0) begin
			sum_neg = 1'b0;
		end
	end

	// One step of the binary GCD.
	logic [GW-1:0] a_nxt, b_nxt;
	logic          k_inc;

	always_comb begin
		a_nxt = a_q;
		b_nxt = b_q;
		k_inc = 1'b0;
		if (!a_q[0] && !b_q[0]) begin
			a_nxt = a_q >> 1;
			b_nxt = b_q >> 1;
			k_inc = 1'b1;
		end else if (!a_q[0]) begin
			a_nxt = a_q >> 1;
		end else if (!b_q[0]) begin
			b_nxt = b_q >> 1;
		end else if (a_q > b_q) begin
			a_nxt = (a_q - b_q) >> 1;
		end else begin
			b_nxt = (b_q - a_q) >> 1;
		end
	end

	// One restoring-division step for each of the two quotients.
	logic [GW:0]   nr_sh, dr_sh, g_ext;
	logic          n_fit, d_fit;

	assign g_ext = {1'b0, g_q};
	assign nr_sh = {nr_q[GW-1:0], nq_q[GW-1]};
	assign dr_sh = {dr_q[GW-1:0], dq_q[GW-1]};
	assign n_fit = nr_sh >= g_ext;
	assign d_fit = dr_sh >= g_ext;

	// Final signed result from the quotients.
	logic          res_neg;
	logic [XN-1:0] n_ext, n_sgn;
	logic [XD-1:0] d_ext;

	assign res_neg = nm_neg_q ^ dn_neg_q;
	assign n_ext   = XN'(nq_q);
	assign n_sgn   = res_neg ? XN'(~n_ext + 1'b1) : n_ext;
	assign d_ext   = XD'(dq_q);

	// Control state: output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload registers of the datapath.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q     <= op_t'(cmd);
			err_q    <= in_err;
			ln_q     <= ln_mag;
			ld_q     <= ld_mag;
			rn_q     <= rn_mag;
			rd_q     <= rd_mag;
			ln_neg_q <= ln_raw[W-1];
			ld_neg_q <= ld_raw[W-1];
			rn_neg_q <= rn_raw[W-1];
			rd_neg_q <= rd_raw[W-1];
		end
		if (ctl.mul1) begin
			t1_q     <= prod;
			t1_neg_q <= prod_neg;
		end
		if (ctl.mul2) begin
			if (op_q == OP_MUL || op_q == OP_DIV) begin
				t2_q     <= '0;
				t2_neg_q <= 1'b0;
			end else begin
				t2_q     <= prod;
				t2_neg_q <= prod_neg;
			end
		end
		if (ctl.mul3) begin
			dn_q     <= prod;
			dn_neg_q <= prod_neg;
		end
		if (ctl.sum) begin
			nm_q     <= sum_mag;
			nm_neg_q <= sum_neg;
		end
		if (ctl.ginit) begin
			a_q <= nm_q;
			b_q <= dn_q;
			k_q <= '0;
		end else if (ctl.gstep) begin
			a_q <= a_nxt;
			b_q <= b_nxt;
			k_q <= k_q + KW'(k_inc);
		end
		if (ctl.dinit) begin
			g_q   <= a_q << k_q;
			nq_q  <= nm_q;
			dq_q  <= dn_q;
			nr_q  <= '0;
			dr_q  <= '0;
			cnt_q <= '0;
		end else if (ctl.dstep) begin
			nr_q  <= n_fit ? (nr_sh - g_ext) : nr_sh;
			dr_q  <= d_fit ? (dr_sh - g_ext) : dr_sh;
			nq_q  <= {nq_q[GW-2:0], n_fit};
			dq_q  <= {dq_q[GW-2:0], d_fit};
			cnt_q <= cnt_q + 1'b1;
		end
		if (ctl.out_load) begin
			if (err_q) begin
				res_num_q <= '0;
				res_den_q <= '0;
				status_q  <= 1'b1;
			end else if (nm_q == '0) begin
				res_num_q <= '0;
				res_den_q <= DEN_W'(1);
				status_q  <= 1'b0;
			end else begin
				res_num_q <= n_sgn[NUM_W-1:0];
				res_den_q <= d_ext[DEN_W-1:0];
				status_q  <= 1'b0;
			end
		end
	end

	// Status back to the controller.
	assign sts.err      = err_q;
	assign sts.num_zero = (nm_q == '0);
	assign sts.gcd_eq   = (a_q == b_q);
	assign sts.div_last = (cnt_q == KW'(GW - 1));
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign result_num = res_num_q;
	assign result_den = res_den_q;
	assign status     = status_q;

endmodule

[rtl/rational_arithmetic_reduce.sv]
// A transaction passes through three multiplies, the signed sum, the binary GCD loop and the
// bit-serial division by the GCD before the result is loaded; an operand error skips to the
// output after the first multiply and a zero numerator after the GCD set-up. One transaction is
// worked on at a time and the next can be taken in the cycle after the result is loaded, so
// throughput is set by the GCD loop and the bit-serial division by the GCD.
// Reset (arst_n, asynchronous, active low) returns the controller to idle and empties the output register.
module rational_arithmetic_reduce #(
	parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rar_pkg::OP_W-1:0]          cmd,
	input  logic signed [OPERAND_WIDTH-1:0]   left_num,
	input  logic signed [OPERAND_WIDTH-1:0]   left_den,
	input  logic signed [OPERAND_WIDTH-1:0]   right_num,
	input  logic signed [OPERAND_WIDTH-1:0]   right_den,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [rar_pkg::NUM_W-1:0]  result_num,
	output logic [rar_pkg::DEN_W-1:0]         result_den,
	output logic                              status
);
	import rar_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// Sequencer for one transaction at a time.
	rar_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	// Multiplier, GCD and division datapath with the output register.
	rar_dp #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.cmd        (cmd),
		.left_num   (left_num),
		.left_den   (left_den),
		.right_num  (right_num),
		.right_den  (right_den),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result_num (result_num),
		.result_den (result_den),
		.status     (status)
	);

endmodule

[rtl/rar_checker.sv]
module rar_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic signed [rar_pkg::NUM_W-1:0] result_num,
	input logic [rar_pkg::DEN_W-1:0]        result_den,
	input logic                             status
);
	import rar_pkg::*;

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_num)
			&& $stable(result_den) && $stable(status))
		else $error("result changed while stalled");

	// Only one transaction is taken at a time.
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	// An error result carries zero fields.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> result_num == '0 && result_den == '0)
		else $error("error result with non-zero fields");

	// A good result has a non-zero denominator.
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status |-> result_den != '0)
		else $error("zero denominator on a good result");

	// A zero result is reported as zero over one.
	a_zero_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status && result_num == '0 |-> result_den == DEN_W'(1))
		else $error("zero result not reduced to one");

endmodule

bind rational_arithmetic_reduce rar_checker u_rar_checker (.*);
